// ===== src/uv_sphere_vertex_generator_top_defines.svh =====
// Assertion helpers for the UV sphere vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define UVS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uvs: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define UVS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uvs: next-cycle check failed");

`endif

// ===== src/uvs_pkg.sv =====
package uvs_pkg;

	localparam int MAX_BANDS = 256;
	localparam int FRAC_BITS = 15;
	localparam int N_TERMS   = 7;
	localparam int DIV_STG   = 4;
	localparam int DIV_BITS  = 8;
	// fold + square + three stages per series term + unfold
	localparam int SC_LAT    = 2 + 3 * N_TERMS + 1;

	localparam logic [30:0] PIO2_Q30    = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [29:0] TURN_EIGHTH = 30'h2000_0000;

	// series divisors and floor(2^32 / divisor)
	localparam logic [7:0] SIN_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
	localparam logic [7:0] COS_DIV [1:7] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
	localparam logic [31:0] SIN_RECIP [1:7] = '{32'd715827882, 32'd214748364, 32'd102261126,
		32'd59652323, 32'd39045157, 32'd27531841, 32'd20452225};
	localparam logic [31:0] COS_RECIP [1:7] = '{32'd2147483648, 32'd357913941, 32'd143165576,
		32'd76695844, 32'd47721858, 32'd32537631, 32'd23598721};

	typedef struct packed {
		logic        valid;
		logic        oor;
		logic        has_quad;
		logic [16:0] first;
		logic [16:0] second;
	} tag_t;

	typedef struct packed {
		logic [9:0] rem;
		logic [7:0] bits;
	} div_step_t;

	// eight restoring division steps, remainder stays below den
	function automatic div_step_t div_step8(input logic [9:0] rem, input logic [9:0] den);
		logic [10:0] r;
		div_step_t   res;
		r = {1'b0, rem};
		res.bits = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[9:0], 1'b0};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				res.bits[DIV_BITS-1-i] = 1'b1;
			end
		end
		res.rem = r[9:0];
		return res;
	endfunction

endpackage

// ===== src/uvs_turn_div.sv =====
module uvs_turn_div import uvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  tag_t        tag_i,
	input  logic [8:0]  lat,
	input  logic [8:0]  lon,
	input  logic [8:0]  lat_bands,
	input  logic [8:0]  lon_bands,
	output tag_t        tag_o,
	output logic [31:0] turn_th,
	output logic [31:0] turn_ph
);

	tag_t       tag_s1;
	logic [9:0] dth_s1, dph_s1, rth_s1, rph_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1        <= tag_i;
			tag_s1.second <= tag_i.first + 17'(lon_bands) + 17'd1;
		end
	end

	// theta divides by 2*lat_bands, phi by lon_bands; integer part of phi dropped (mod turn)
	always_ff @(posedge clk) begin
		if (adv) begin
			dth_s1 <= {lat_bands, 1'b0};
			dph_s1 <= {1'b0, lon_bands};
			rth_s1 <= {1'b0, lat};
			rph_s1 <= (lon >= lon_bands) ? {1'b0, lon - lon_bands} : {1'b0, lon};
		end
	end

	tag_t        tag_c [0:DIV_STG];
	logic [9:0]  dth_c [0:DIV_STG];
	logic [9:0]  dph_c [0:DIV_STG];
	logic [9:0]  rth_c [0:DIV_STG];
	logic [9:0]  rph_c [0:DIV_STG];
	logic [31:0] qth_c [0:DIV_STG];
	logic [31:0] qph_c [0:DIV_STG];

	assign tag_c[0] = tag_s1;
	assign dth_c[0] = dth_s1;
	assign dph_c[0] = dph_s1;
	assign rth_c[0] = rth_s1;
	assign rph_c[0] = rph_s1;
	assign qth_c[0] = '0;
	assign qph_c[0] = '0;

	for (genvar j = 0; j < DIV_STG; j++) begin : g_div
		div_step_t   sth, sph;
		tag_t        tag_s1;
		logic [9:0]  dth_s1, dph_s1, rth_s1, rph_s1;
		logic [31:0] qth_s1, qph_s1;

		always_comb begin
			sth = div_step8(rth_c[j], dth_c[j]);
			sph = div_step8(rph_c[j], dph_c[j]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s1 <= '0;
			end else if (adv) begin
				tag_s1 <= tag_c[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dth_s1 <= dth_c[j];
				dph_s1 <= dph_c[j];
				rth_s1 <= sth.rem;
				rph_s1 <= sph.rem;
				qth_s1 <= {qth_c[j][31-DIV_BITS:0], sth.bits};
				qph_s1 <= {qph_c[j][31-DIV_BITS:0], sph.bits};
			end
		end

		assign tag_c[j+1] = tag_s1;
		assign dth_c[j+1] = dth_s1;
		assign dph_c[j+1] = dph_s1;
		assign rth_c[j+1] = rth_s1;
		assign rph_c[j+1] = rph_s1;
		assign qth_c[j+1] = qth_s1;
		assign qph_c[j+1] = qph_s1;
	end

	assign tag_o   = tag_c[DIV_STG];
	assign turn_th = qth_c[DIV_STG];
	assign turn_ph = qph_c[DIV_STG];

endmodule

// ===== src/uvs_sincos.sv =====
module uvs_sincos import uvs_pkg::*; (
	input  logic               clk,
	input  logic               adv,
	input  logic [31:0]        turn,
	output logic signed [31:0] sin_o,
	output logic signed [31:0] cos_o
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// fold to first octant, convert to radians Q30
	logic [29:0] r_fold;
	logic        swap;
	logic [30:0] r_mir;
	logic [60:0] p_rad;

	always_comb begin
		swap   = turn[29:0] > TURN_EIGHTH;
		r_mir  = Q30_ONE - {1'b0, turn[29:0]};
		r_fold = swap ? r_mir[29:0] : turn[29:0];
		p_rad  = 61'(r_fold) * 61'(PIO2_Q30);
	end

	logic [29:0] x_s1;
	logic [2:0]  oct_s1;
	logic [29:0] x_s2, x2_s2;
	logic [2:0]  oct_s2;
	logic [59:0] p_sq;

	assign p_sq = 60'(x_s1) * 60'(x_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= p_rad[59:30];
			oct_s1 <= {turn[31:30], swap};
			x_s2   <= x_s1;
			x2_s2  <= p_sq[59:30];
			oct_s2 <= oct_s1;
		end
	end

	// chain: accumulators hold terms before index k, term k is added one block later
	logic [29:0]        ts_c  [0:N_TERMS];
	logic [30:0]        tc_c  [0:N_TERMS];
	logic signed [31:0] as_c  [0:N_TERMS];
	logic signed [31:0] ac_c  [0:N_TERMS];
	logic [29:0]        x2_c  [0:N_TERMS];
	logic [2:0]         oct_c [0:N_TERMS];

	assign ts_c[0]  = x_s2;
	assign tc_c[0]  = Q30_ONE;
	assign as_c[0]  = '0;
	assign ac_c[0]  = '0;
	assign x2_c[0]  = x2_s2;
	assign oct_c[0] = oct_s2;

	for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
		localparam bit NEG_PREV = ((k - 1) % 2) == 1;

		logic [59:0]        ms;
		logic [60:0]        mc;
		logic [61:0]        qs_p, qc_p;
		logic [29:0]        rs, rc;
		logic [29:0]        ns_s1, nc_s1;
		logic signed [31:0] as_s1, ac_s1;
		logic [29:0]        x2_s1;
		logic [2:0]         oct_s1;
		logic [29:0]        ns_s2, nc_s2, qs_s2, qc_s2;
		logic signed [31:0] as_s2, ac_s2;
		logic [29:0]        x2_s2;
		logic [2:0]         oct_s2;
		logic [29:0]        ts_s3, tc_s3;
		logic signed [31:0] as_s3, ac_s3;
		logic [29:0]        x2_s3;
		logic [2:0]         oct_s3;

		always_comb begin
			ms   = 60'(ts_c[k-1]) * 60'(x2_c[k-1]);
			mc   = 61'(tc_c[k-1]) * 61'(x2_c[k-1]);
			qs_p = 62'(ns_s1) * 62'(SIN_RECIP[k]);
			qc_p = 62'(nc_s1) * 62'(COS_RECIP[k]);
			rs   = ns_s2 - 30'(38'(qs_s2) * 38'(SIN_DIV[k]));
			rc   = nc_s2 - 30'(38'(qc_s2) * 38'(COS_DIV[k]));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ns_s1  <= ms[59:30];
				nc_s1  <= mc[59:30];
				if (NEG_PREV) begin
					as_s1 <= as_c[k-1] - $signed({2'b00, ts_c[k-1]});
					ac_s1 <= ac_c[k-1] - $signed({1'b0, tc_c[k-1]});
				end else begin
					as_s1 <= as_c[k-1] + $signed({2'b00, ts_c[k-1]});
					ac_s1 <= ac_c[k-1] + $signed({1'b0, tc_c[k-1]});
				end
				x2_s1  <= x2_c[k-1];
				oct_s1 <= oct_c[k-1];

				// reciprocal estimate is exact or one low
				ns_s2  <= ns_s1;
				nc_s2  <= nc_s1;
				qs_s2  <= qs_p[61:32];
				qc_s2  <= qc_p[61:32];
				as_s2  <= as_s1;
				ac_s2  <= ac_s1;
				x2_s2  <= x2_s1;
				oct_s2 <= oct_s1;

				ts_s3  <= (rs >= 30'(SIN_DIV[k])) ? qs_s2 + 30'd1 : qs_s2;
				tc_s3  <= (rc >= 30'(COS_DIV[k])) ? qc_s2 + 30'd1 : qc_s2;
				as_s3  <= as_s2;
				ac_s3  <= ac_s2;
				x2_s3  <= x2_s2;
				oct_s3 <= oct_s2;
			end
		end

		assign ts_c[k]  = ts_s3;
		assign tc_c[k]  = {1'b0, tc_s3};
		assign as_c[k]  = as_s3;
		assign ac_c[k]  = ac_s3;
		assign x2_c[k]  = x2_s3;
		assign oct_c[k] = oct_s3;
	end

	// last term (odd index, subtracted), then unfold octant and quadrant
	logic signed [31:0] s_f, c_f, s_sw, c_sw;
	logic signed [31:0] sin_s3, cos_s3;

	always_comb begin
		s_f  = as_c[N_TERMS] - $signed({2'b00, ts_c[N_TERMS]});
		c_f  = ac_c[N_TERMS] - $signed({1'b0, tc_c[N_TERMS]});
		s_sw = oct_c[N_TERMS][0] ? c_f : s_f;
		c_sw = oct_c[N_TERMS][0] ? s_f : c_f;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (oct_c[N_TERMS][2:1])
				QUAD_0: begin sin_s3 <= s_sw;  cos_s3 <= c_sw;  end
				QUAD_1: begin sin_s3 <= c_sw;  cos_s3 <= -s_sw; end
				QUAD_2: begin sin_s3 <= -s_sw; cos_s3 <= -c_sw; end
				QUAD_3: begin sin_s3 <= -c_sw; cos_s3 <= s_sw;  end
				default: begin sin_s3 <= s_sw; cos_s3 <= c_sw;  end
			endcase
		end
	end

	assign sin_o = sin_s3;
	assign cos_o = cos_s3;

endmodule

// ===== src/uvs_vertex_out.sv =====
module uvs_vertex_out import uvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  tag_t               tag_i,
	input  logic signed [31:0] sin_th,
	input  logic signed [31:0] cos_th,
	input  logic signed [31:0] sin_ph,
	input  logic signed [31:0] cos_ph,
	input  logic [15:0]        radius,
	output tag_t               tag_o,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z
);

	localparam int          SH_XZ  = 60 - FRAC_BITS;
	localparam int          SH_Y   = 30 - FRAC_BITS;
	localparam logic [16:0] N_LIM  = 17'((1 << FRAC_BITS) - 1);

	function automatic logic [30:0] mag31(input logic signed [31:0] v);
		return v[31] ? 31'(-v) : 31'(v);
	endfunction

	tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_i;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// stage 1: magnitude products
	logic [61:0] px_s1, pz_s1;
	logic [30:0] my_s1;
	logic        nx_neg_s1, ny_neg_s1, nz_neg_s1;

	// stage 2: round and saturate normals
	logic [61:0] sx, sz;
	logic [31:0] sy;
	logic [16:0] vx, vy, vz;
	logic [14:0] mx_s2, my_s2, mz_s2;
	logic        nx_neg_s2, ny_neg_s2, nz_neg_s2;

	always_comb begin
		sx = px_s1 + (62'd1 << (SH_XZ - 1));
		sz = pz_s1 + (62'd1 << (SH_XZ - 1));
		sy = 32'(my_s1) + (32'd1 << (SH_Y - 1));
		vx = 17'(sx >> SH_XZ);
		vz = 17'(sz >> SH_XZ);
		vy = 17'(sy >> SH_Y);
	end

	// stage 3: radius products
	logic [30:0] rx_s3, ry_s3, rz_s3;
	logic [14:0] mx_s3, my_s3, mz_s3;
	logic        nx_neg_s3, ny_neg_s3, nz_neg_s3;

	// stage 4: round positions, apply sign, zero rejected points
	logic [31:0] ux, uy, uz;
	logic [15:0] wx, wy, wz;

	always_comb begin
		ux = 32'(rx_s3) + (32'd1 << (FRAC_BITS - 1));
		uy = 32'(ry_s3) + (32'd1 << (FRAC_BITS - 1));
		uz = 32'(rz_s3) + (32'd1 << (FRAC_BITS - 1));
		wx = 16'(ux >> FRAC_BITS);
		wy = 16'(uy >> FRAC_BITS);
		wz = 16'(uz >> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1     <= 62'(mag31(cos_ph)) * 62'(mag31(sin_th));
			pz_s1     <= 62'(mag31(sin_ph)) * 62'(mag31(sin_th));
			my_s1     <= mag31(cos_th);
			nx_neg_s1 <= cos_ph[31] ^ sin_th[31];
			nz_neg_s1 <= sin_ph[31] ^ sin_th[31];
			ny_neg_s1 <= cos_th[31];

			mx_s2     <= (vx > N_LIM) ? N_LIM[14:0] : vx[14:0];
			my_s2     <= (vy > N_LIM) ? N_LIM[14:0] : vy[14:0];
			mz_s2     <= (vz > N_LIM) ? N_LIM[14:0] : vz[14:0];
			nx_neg_s2 <= nx_neg_s1;
			ny_neg_s2 <= ny_neg_s1;
			nz_neg_s2 <= nz_neg_s1;

			rx_s3     <= 31'(radius) * 31'(mx_s2);
			ry_s3     <= 31'(radius) * 31'(my_s2);
			rz_s3     <= 31'(radius) * 31'(mz_s2);
			mx_s3     <= mx_s2;
			my_s3     <= my_s2;
			mz_s3     <= mz_s2;
			nx_neg_s3 <= nx_neg_s2;
			ny_neg_s3 <= ny_neg_s2;
			nz_neg_s3 <= nz_neg_s2;

			if (tag_s3.oor) begin
				normal_x <= '0;
				normal_y <= '0;
				normal_z <= '0;
				pos_x    <= '0;
				pos_y    <= '0;
				pos_z    <= '0;
			end else begin
				normal_x <= nx_neg_s3 ? -$signed({1'b0, mx_s3}) : $signed({1'b0, mx_s3});
				normal_y <= ny_neg_s3 ? -$signed({1'b0, my_s3}) : $signed({1'b0, my_s3});
				normal_z <= nz_neg_s3 ? -$signed({1'b0, mz_s3}) : $signed({1'b0, mz_s3});
				pos_x    <= nx_neg_s3 ? -$signed({1'b0, wx}) : $signed({1'b0, wx});
				pos_y    <= ny_neg_s3 ? -$signed({1'b0, wy}) : $signed({1'b0, wy});
				pos_z    <= nz_neg_s3 ? -$signed({1'b0, wz}) : $signed({1'b0, wz});
			end
		end
	end

	assign tag_o = tag_s4;

endmodule

// ===== src/uv_sphere_vertex_generator_top.sv =====
// Channel  | Handshake                  | Carries
// ---------+----------------------------+------------------------------------------
// point    | point_valid / point_stall  | lat_index, lon_index (one grid point)
// vertex   | vertex_valid / vertex_stall| normal, position, quad indices, flags
// config   | APB psel/penable/pwrite    | lat_bands @0x0, lon_bands @0x4, radius @0x8
//
// One transaction per clock sustained while the vertex output is not stalled.
// Stages: input register, turn divider (eight quotient bits per stage), sine/cosine
// (three stages per series term), output scaling.
// All stages advance together; a stalled vertex freezes the whole pipe, nothing lost.
// Reset clears valid bits and loads lat_bands=16, lon_bands=16, radius=1.0 (Q8.8).
`include "uv_sphere_vertex_generator_top_defines.svh"

module uv_sphere_vertex_generator_top import uvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               point_valid,
	output logic               point_stall,
	input  logic [8:0]         lat_index,
	input  logic [8:0]         lon_index,

	output logic               vertex_valid,
	input  logic               vertex_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic [16:0]        first_index,
	output logic [16:0]        second_index,
	output logic               has_quad,
	output logic               out_of_range,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [1:0] REG_LAT_BANDS = 2'd0;
	localparam logic [1:0] REG_LON_BANDS = 2'd1;
	localparam logic [1:0] REG_RADIUS    = 2'd2;

	// ---------------- configuration registers ----------------
	logic [8:0]  lat_bands_q, lon_bands_q;
	logic [15:0] radius_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_bands_q <= 9'd16;
			lon_bands_q <= 9'd16;
			radius_q    <= 16'd256;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LAT_BANDS: lat_bands_q <= pwdata[8:0];
				REG_LON_BANDS: lon_bands_q <= pwdata[8:0];
				REG_RADIUS:    radius_q    <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LAT_BANDS: prdata = {23'd0, lat_bands_q};
			REG_LON_BANDS: prdata = {23'd0, lon_bands_q};
			REG_RADIUS:    prdata = {16'd0, radius_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- pipeline advance ----------------
	// the whole pipe moves unless the finished vertex is held at the output
	logic adv;
	assign adv         = !(vertex_valid && vertex_stall);
	assign point_stall = !adv;

	// ---------------- stage 1: range check and first index ----------------
	tag_t        tag_s1;
	logic [8:0]  lat_s1, lon_s1;
	logic        bad_bands, oor_in;
	logic [18:0] first_full;

	always_comb begin
		bad_bands  = (lat_bands_q == 9'd0) || (lon_bands_q == 9'd0) ||
			(lat_bands_q > 9'(MAX_BANDS)) || (lon_bands_q > 9'(MAX_BANDS));
		oor_in     = bad_bands || (lat_index > lat_bands_q) || (lon_index > lon_bands_q);
		first_full = 19'(lat_index) * 19'({1'b0, lon_bands_q} + 10'd1) + 19'(lon_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid    <= point_valid;
			tag_s1.oor      <= oor_in;
			tag_s1.has_quad <= !oor_in && (lat_index < lat_bands_q) && (lon_index < lon_bands_q);
			tag_s1.first    <= oor_in ? 17'd0 : first_full[16:0];
			tag_s1.second   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lat_s1 <= lat_index;
			lon_s1 <= lon_index;
		end
	end

	// ---------------- angles as fractions of a turn ----------------
	tag_t        div_tag;
	logic [31:0] turn_th, turn_ph;

	uvs_turn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tag_i     (tag_s1),
		.lat       (lat_s1),
		.lon       (lon_s1),
		.lat_bands (lat_bands_q),
		.lon_bands (lon_bands_q),
		.tag_o     (div_tag),
		.turn_th   (turn_th),
		.turn_ph   (turn_ph)
	);

	// ---------------- sine and cosine of both angles ----------------
	logic signed [31:0] sin_th, cos_th, sin_ph, cos_ph;

	uvs_sincos u_sc_th (
		.clk   (clk),
		.adv   (adv),
		.turn  (turn_th),
		.sin_o (sin_th),
		.cos_o (cos_th)
	);

	uvs_sincos u_sc_ph (
		.clk   (clk),
		.adv   (adv),
		.turn  (turn_ph),
		.sin_o (sin_ph),
		.cos_o (cos_ph)
	);

	// valid bit and indices ride alongside the sine/cosine stages
	tag_t sc_tag_s [1:SC_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= SC_LAT; i++) sc_tag_s[i] <= '0;
		end else if (adv) begin
			sc_tag_s[1] <= div_tag;
			for (int i = 2; i <= SC_LAT; i++) sc_tag_s[i] <= sc_tag_s[i-1];
		end
	end

	// ---------------- normal, position, output register ----------------
	tag_t out_tag;

	uvs_vertex_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.tag_i    (sc_tag_s[SC_LAT]),
		.sin_th   (sin_th),
		.cos_th   (cos_th),
		.sin_ph   (sin_ph),
		.cos_ph   (cos_ph),
		.radius   (radius_q),
		.tag_o    (out_tag),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z)
	);

	assign vertex_valid = out_tag.valid;
	assign out_of_range = out_tag.oor;
	assign has_quad     = out_tag.has_quad;
	assign first_index  = out_tag.oor ? 17'd0 : out_tag.first;
	assign second_index = out_tag.oor ? 17'd0 : out_tag.second;

	// ---------------- checks ----------------
	`UVS_ASSERT_IMP(a_oor_zero, clk, arst_n, vertex_valid && out_of_range, normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0 && pos_x == 17'sd0 && pos_y == 17'sd0 && pos_z == 17'sd0 && !has_quad)
	`UVS_ASSERT_IMP(a_second_idx, clk, arst_n, vertex_valid && !out_of_range, second_index == first_index + 17'(lon_bands_q) + 17'd1)
	`UVS_ASSERT_IMP(a_norm_sat, clk, arst_n, vertex_valid, normal_x != 16'sh8000 && normal_y != 16'sh8000 && normal_z != 16'sh8000)
	`UVS_ASSERT_NXT(a_s1_hold, clk, arst_n, tag_s1.valid && point_stall, tag_s1.valid)

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import uvs_pkg::*;

	// Expected vertex, one per accepted grid point
	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic signed [16:0] px, py, pz;
		logic [16:0]        first, second;
		logic               quad, oor;
	} vertex_t;

	localparam logic [3:0] ADDR_LAT_BANDS = 4'h0;
	localparam logic [3:0] ADDR_LON_BANDS = 4'h4;
	localparam logic [3:0] ADDR_RADIUS    = 4'h8;
	localparam logic [3:0] ADDR_UNUSED    = 4'hC;
	localparam int PIPE_LAT  = 34;
	localparam int WDOG_LIM  = 20000;

	// Scoreboard: in-order queue of predicted vertices
	class vertex_scoreboard;
		vertex_t pending[$];
		int      errors;
		int      checked;

		function void note_point(vertex_t v);
			pending.insert(pending.size(), v);
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t e;
			if (pending.size() == 0) begin
				$error("vertex with no grid point pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.nx !== e.nx) begin $error("normal_x exp %0d got %0d", e.nx, got.nx); errors++; end
			if (got.ny !== e.ny) begin $error("normal_y exp %0d got %0d", e.ny, got.ny); errors++; end
			if (got.nz !== e.nz) begin $error("normal_z exp %0d got %0d", e.nz, got.nz); errors++; end
			if (got.px !== e.px) begin $error("pos_x exp %0d got %0d", e.px, got.px); errors++; end
			if (got.py !== e.py) begin $error("pos_y exp %0d got %0d", e.py, got.py); errors++; end
			if (got.pz !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, got.pz); errors++; end
			if (got.first !== e.first) begin
				$error("first_index exp %0d got %0d", e.first, got.first); errors++;
			end
			if (got.second !== e.second) begin
				$error("second_index exp %0d got %0d", e.second, got.second); errors++;
			end
			if (got.quad !== e.quad) begin $error("has_quad exp %0d got %0d", e.quad, got.quad); errors++; end
			if (got.oor !== e.oor) begin
				$error("out_of_range exp %0d got %0d", e.oor, got.oor); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic point_valid, point_stall;
	logic [8:0] lat_index, lon_index;
	logic vertex_valid, vertex_stall;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic [16:0] first_index, second_index;
	logic has_quad, out_of_range;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	uv_sphere_vertex_generator_top uut (.*);

	// Shadow copy of the register file
	logic [8:0]  cfg_lat, cfg_lon;
	logic [15:0] cfg_radius;

	vertex_scoreboard sb;
	int  send_idle_pct, recv_stall_pct;
	bit  hold_recv;
	int  points_sent;
	int  idle_cycles;
	bit  done;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------
	// sin/cos of a 32-bit turn fraction, Q30
	function automatic void turn_sincos(input logic [31:0] a,
		output longint sn, output longint cs);
		logic [1:0]  quad;
		logic [31:0] r;
		bit          swp;
		logic [63:0] x, x2, term;
		longint      s, c, t;
		quad = a[31:30];
		r = {2'b00, a[29:0]};
		swp = 0;
		if (r > 32'h2000_0000) begin
			r = 32'h4000_0000 - r;
			swp = 1;
		end
		x  = (64'(r) * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		s = longint'(x);
		term = x;
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			s += (k & 1) ? -longint'(term) : longint'(term);
		end
		c = 64'd1073741824;
		term = 64'd1073741824;
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			c += (k & 1) ? -longint'(term) : longint'(term);
		end
		if (swp) begin
			t = s; s = c; c = t;
		end
		case (quad)
			2'd0: begin sn = s;  cs = c;  end
			2'd1: begin sn = c;  cs = -s; end
			2'd2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// round right by sh, halves away from zero, saturate at 32767 (largest Q15 below 1.0)
	function automatic longint q15_round(logic [63:0] mag, int sh, bit neg);
		logic [63:0] v;
		v = (mag + (64'd1 << (sh - 1))) >> sh;
		if (v > 64'd32767) v = 64'd32767;
		return neg ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint norm_product(longint a, longint b);
		return q15_round(64'(abs64(a)) * 64'(abs64(b)), 60 - FRAC_BITS, (a < 0) != (b < 0));
	endfunction

	function automatic longint radius_scale(longint n);
		logic [63:0] v;
		v = (64'(cfg_radius) * 64'(abs64(n)) + 64'd16384) >> FRAC_BITS;
		return n < 0 ? -longint'(v) : longint'(v);
	endfunction

	function automatic vertex_t predict_vertex(logic [8:0] lat, logic [8:0] lon);
		vertex_t v;
		longint st, ct, sp, cp, nx, ny, nz;
		logic [63:0] ta, pa, first;
		v = '{default: 0};
		if (cfg_lat == 0 || cfg_lon == 0 || cfg_lat > MAX_BANDS || cfg_lon > MAX_BANDS ||
			lat > cfg_lat || lon > cfg_lon) begin
			v.oor = 1;
			return v;
		end
		ta = (64'(lat) << 32) / (64'(cfg_lat) * 2);
		pa = (64'(lon) << 32) / 64'(cfg_lon);
		turn_sincos(ta[31:0], st, ct);
		turn_sincos(pa[31:0], sp, cp);
		nx = norm_product(cp, st);
		ny = q15_round(64'(abs64(ct)), 30 - FRAC_BITS, ct < 0);
		nz = norm_product(sp, st);
		first = 64'(lat) * (64'(cfg_lon) + 1) + 64'(lon);
		v.nx = nx[15:0]; v.ny = ny[15:0]; v.nz = nz[15:0];
		v.px = 17'(radius_scale(nx));
		v.py = 17'(radius_scale(ny));
		v.pz = 17'(radius_scale(nz));
		v.first  = first[16:0];
		v.second = 17'(first + 64'(cfg_lon) + 1);
		v.quad = (lat < cfg_lat) && (lon < cfg_lon);
		return v;
	endfunction

	// ---------------- drivers ----------------
	task automatic reg_write(logic [3:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		case (addr)
			ADDR_LAT_BANDS: cfg_lat = data[8:0];
			ADDR_LON_BANDS: cfg_lon = data[8:0];
			ADDR_RADIUS:    cfg_radius = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_sphere(int lat_b, int lon_b, int rad);
		reg_write(ADDR_LAT_BANDS, 32'(lat_b));
		reg_write(ADDR_LON_BANDS, 32'(lon_b));
		reg_write(ADDR_RADIUS, 32'(rad));
	endtask

	// offer one grid point; random idle before it; held until accepted
	task automatic send_point(logic [8:0] lat, logic [8:0] lon);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
		point_valid = 1;
		lat_index = lat;
		lon_index = lon;
		do @(posedge clk); while (point_stall);
		sb.note_point(predict_vertex(lat, lon));
		points_sent++;
		@(negedge clk);
		point_valid = 0;
	endtask

	// wait for the pipe to drain, then cover points an idle ignored item might still hold
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	// mostly in-range points, a slice of out-of-range and raw-noise points
	task automatic random_points(int n);
		logic [8:0] la, lo;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin la = 9'($urandom); lo = 9'($urandom); end
				1: begin la = 9'(cfg_lat + $urandom_range(1, 3)); lo = 9'($urandom_range(0, cfg_lon)); end
				2: begin la = 9'($urandom_range(0, cfg_lat)); lo = 9'(cfg_lon + $urandom_range(1, 3)); end
				default: begin la = 9'($urandom_range(0, cfg_lat)); lo = 9'($urandom_range(0, cfg_lon)); end
			endcase
			send_point(la, lo);
		end
	endtask

	// receiver: random stall, or a long hold-off when asked
	always @(negedge clk) begin
		if (!arst_n)
			vertex_stall <= 0;
		else if (hold_recv)
			vertex_stall <= 1;
		else
			vertex_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: check each accepted vertex
	always @(posedge clk) begin
		vertex_t got;
		if (arst_n && vertex_valid && !vertex_stall) begin
			got.nx = normal_x; got.ny = normal_y; got.nz = normal_z;
			got.px = pos_x; got.py = pos_y; got.pz = pos_z;
			got.first = first_index; got.second = second_index;
			got.quad = has_quad; got.oor = out_of_range;
			sb.check_vertex(got);
		end
	end

	// watchdog: cycles with no transaction on the point, vertex or config channel
	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (vertex_valid && !vertex_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_LIM && !done) begin
			$display("watchdog expired, %0d vertices still pending", sb.pending.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		sb = new();
		arst_n = 0;
		point_valid = 0; lat_index = 0; lon_index = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 0;
		points_sent = 0; idle_cycles = 0; done = 0;
		cfg_lat = 16; cfg_lon = 16; cfg_radius = 256;
		repeat (7) @(negedge clk);
		arst_n = 1;

		// directed: reset values, poles, seam, last row/col, out of range
		send_point(0, 0);
		send_point(16, 16);
		send_point(8, 4);
		send_point(8, 12);
		send_point(15, 15);
		send_point(17, 0);
		send_point(0, 17);
		send_point(9'h1FF, 9'h1FF);
		send_point(4, 2);
		drain();
		set_sphere(256, 256, 65535);   // largest sphere
		send_point(256, 256);
		send_point(128, 64);
		send_point(255, 255);
		send_point(1, 1);
		send_point(257, 0);
		send_point(9'h0AA, 9'h155);
		send_point(9'h155, 9'h0AA);
		drain();
		set_sphere(1, 1, 0);           // smallest bands, zero radius
		send_point(0, 0);
		send_point(1, 1);
		send_point(2, 0);
		drain();
		set_sphere(0, 300, 256);       // illegal band counts
		send_point(0, 0);
		send_point(1, 5);
		drain();
		reg_write(ADDR_UNUSED, 32'hFFFF_FFFF); // ignored register
		set_sphere(7, 3, 32768);
		send_point(7, 3);
		send_point(3, 1);
		drain();

		// random phases over settings and idling mixes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			if (ph == 7)
				set_sphere(256, 256, 65535);
			else
				set_sphere($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 65535));
			random_points(60);
			drain();
		end

		// back-pressure: receiver holds off long, sender keeps offering
		send_idle_pct = 0; recv_stall_pct = 0;
		set_sphere(12, 20, 512);
		fork
			begin
				hold_recv = 1;
				repeat (200) @(negedge clk);
				hold_recv = 0;
			end
			random_points(60);
		join
		drain();

		done = 1;
		repeat (PIPE_LAT) @(negedge clk);
		$display("Sent %0d grid points, checked %0d vertices over band/radius extremes,",
			points_sent, sb.checked);
		$display("out-of-range points, idle and stall mixes, and a long output hold-off.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
